[hdl/act_pkg.sv]
// Package for the animation channel tween block: codes and constants.
// No dependencies; imported by animation_channel_tween.
`default_nettype none
package act_pkg;

	typedef enum logic [1:0] {
		MODE_FIXED  = 2'd0,
		MODE_FROMTO = 2'd1,
		MODE_PVA    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_RENDER  = 2'd1,
		ST_DESTROY = 2'd2
	} status_t;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_START  = 3'd1;
	localparam logic [2:0] REG_END    = 3'd2;
	localparam logic [2:0] REG_FIRST  = 3'd3;
	localparam logic [2:0] REG_SECOND = 3'd4;
	localparam logic [2:0] REG_ACCEL  = 3'd5;

	localparam int unsigned PVA_DEN = 2000000;
	localparam int unsigned VEL_SCALE = 2000;
	localparam int unsigned END_RESET = 1000;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned SUM_W = 99;

endpackage
`default_nettype wire

[hdl/animation_channel_tween.sv]
// Animation channel tween: evaluates one animated Q16.16 channel per timestamp.
// An accepted input transaction passes stages 1 to 6, the divider and the output register to the master side.
// Throughput: one transaction per cycle; the whole pipeline stalls only while a result
// waits on the master side and m_tready is low.
// Latency set mostly by a 32-stage restoring divider, one quotient bit per stage, shared by modes.
// Reset (arst_n low, asynchronous): configuration and valid registers return to their reset values, pipeline empties.
`default_nettype none
module animation_channel_tween (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side: tdata = now_ms[31:0]
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,
	// master side: tdata = value[31:0]; tuser = status[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic [1:0]       m_tuser,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import act_pkg::*;

	// configuration registers
	logic [1:0]  mode_q;
	logic [31:0] start_q, end_q, first_q, second_q, accel_q;

	// values derived from configuration, registered from the configuration registers; first use is
	// in the second pipeline stage, so they are settled before any item needs them
	logic [31:0] d_q;
	logic        empty_q;
	logic [31:0] m_q;
	logic        dneg_q;
	logic [31:0] magv_q, maga_q;
	logic        sv_q, sa_q, sf_q;
	logic [52:0] t1_q;

	logic adv;
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FIXED;
			start_q  <= '0;
			end_q    <= 32'(END_RESET);
			first_q  <= '0;
			second_q <= '0;
			accel_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_START:  start_q  <= cfg_data;
				REG_END:    end_q    <= cfg_data;
				REG_FIRST:  first_q  <= cfg_data;
				REG_SECOND: second_q <= cfg_data;
				REG_ACCEL:  accel_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [32:0] diff_w;
	assign diff_w = {second_q[31], second_q} - {first_q[31], first_q};

	// magnitude of the base value, kept at 32 bits so -2^31 maps to 2^31
	logic [31:0] magf_w;
	assign magf_w = first_q[31] ? -first_q : first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= 32'(END_RESET);
			empty_q <= 1'b0;
			m_q     <= '0;
			dneg_q  <= 1'b0;
			magv_q  <= '0;
			maga_q  <= '0;
			sv_q    <= 1'b0;
			sa_q    <= 1'b0;
			sf_q    <= 1'b0;
			t1_q    <= '0;
		end else begin
			d_q     <= end_q - start_q;
			empty_q <= end_q <= start_q;
			dneg_q  <= diff_w[32];
			m_q     <= diff_w[32] ? 32'(-diff_w) : diff_w[31:0];
			sv_q    <= second_q[31];
			sa_q    <= accel_q[31];
			sf_q    <= first_q[31];
			magv_q  <= second_q[31] ? -second_q : second_q;
			maga_q  <= accel_q[31] ? -accel_q : accel_q;
			t1_q    <= 53'(magf_w) * 53'(PVA_DEN);
		end
	end

	// pipeline registers
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        before_s1;
	logic [31:0] e_s1;
	status_t     st_s2, st_s3, st_s4, st_s5, st_s6;
	logic [63:0] me_s2, me_s3, me_s4, me_s5, me_s6;
	logic [63:0] ve_s2, ee_s2;
	logic [42:0] p2lo_s3, p2hi_s3;
	logic [63:0] p3lo_s3, p3hi_s3;
	logic [74:0] t2_s4;
	logic [95:0] t3_s4;
	logic [SUM_W-1:0] sum_s5, abs_s6;
	logic        neg_s6;

	// divider chain; index 0 is the seventh stage that loads the dividend
	logic        div_vld_s [DIV_STEPS+1];
	status_t     div_st_s  [DIV_STEPS+1];
	logic        div_neg_s [DIV_STEPS+1];
	logic        div_sat_s [DIV_STEPS+1];
	logic [31:0] div_rem_s [DIV_STEPS+1];
	logic [31:0] div_low_s [DIV_STEPS+1];

	logic [32:0] in_diff_w;
	assign in_diff_w = {1'b0, s_tdata} - {1'b0, start_q};

	logic [31:0] divisor_w;
	assign divisor_w = (mode_t'(mode_q) == MODE_FROMTO) ? d_q : 32'(PVA_DEN);

	logic [SUM_W-1:0] t1x_w, t2x_w, t3x_w;
	assign t1x_w = sf_q ? -SUM_W'(t1_q) : SUM_W'(t1_q);
	assign t2x_w = sv_q ? -SUM_W'(t2_s4) : SUM_W'(t2_s4);
	assign t3x_w = sa_q ? -SUM_W'(t3_s4) : SUM_W'(t3_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: elapsed time, borrow marks a timestamp before start
			e_s1      <= in_diff_w[31:0];
			before_s1 <= in_diff_w[32];
			// stage 2: status and the 32x32 products
			if (before_s1)
				st_s2 <= ST_NONE;
			else if (empty_q || (e_s1 > d_q))
				st_s2 <= ST_DESTROY;
			else
				st_s2 <= ST_RENDER;
			me_s2 <= m_q * e_s1;
			ve_s2 <= magv_q * e_s1;
			ee_s2 <= e_s1 * e_s1;
			// stage 3: partial products of the wide terms
			st_s3   <= st_s2;
			me_s3   <= me_s2;
			p2lo_s3 <= ve_s2[31:0] * 43'(VEL_SCALE);
			p2hi_s3 <= ve_s2[63:32] * 43'(VEL_SCALE);
			p3lo_s3 <= ee_s2[31:0] * maga_q;
			p3hi_s3 <= ee_s2[63:32] * maga_q;
			// stage 4: combine partial products
			st_s4 <= st_s3;
			me_s4 <= me_s3;
			t2_s4 <= 75'(p2lo_s3) + {p2hi_s3[42:0], 32'd0};
			t3_s4 <= 96'(p3lo_s3) + {p3hi_s3, 32'd0};
			// stage 5: signed sum of the three PVA terms
			st_s5  <= st_s4;
			me_s5  <= me_s4;
			sum_s5 <= t1x_w + t2x_w + t3x_w;
			// stage 6: split into sign and magnitude
			st_s6  <= st_s5;
			me_s6  <= me_s5;
			neg_s6 <= sum_s5[SUM_W-1];
			abs_s6 <= sum_s5[SUM_W-1] ? -sum_s5 : sum_s5;
		end
	end

	// stage 7 and the divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++)
				div_vld_s[k] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= vld_s6;
			for (int k = 1; k <= DIV_STEPS; k++)
				div_vld_s[k] <= div_vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [32:0] cur;
		if (adv) begin
			div_st_s[0]  <= st_s6;
			div_neg_s[0] <= neg_s6;
			// quotient at or above 2^32 saturates either way
			div_sat_s[0] <= abs_s6[SUM_W-1:32] >= (SUM_W-32)'(PVA_DEN);
			if (mode_t'(mode_q) == MODE_FROMTO) begin
				div_rem_s[0] <= me_s6[63:32];
				div_low_s[0] <= me_s6[31:0];
			end else begin
				div_rem_s[0] <= abs_s6[63:32];
				div_low_s[0] <= abs_s6[31:0];
			end
			for (int k = 1; k <= DIV_STEPS; k++) begin
				cur = {div_rem_s[k-1], div_low_s[k-1][31]};
				div_st_s[k]  <= div_st_s[k-1];
				div_neg_s[k] <= div_neg_s[k-1];
				div_sat_s[k] <= div_sat_s[k-1];
				if (cur >= {1'b0, divisor_w}) begin
					div_rem_s[k] <= 32'(cur - {1'b0, divisor_w});
					div_low_s[k] <= {div_low_s[k-1][30:0], 1'b1};
				end else begin
					div_rem_s[k] <= cur[31:0];
					div_low_s[k] <= {div_low_s[k-1][30:0], 1'b0};
				end
			end
		end
	end

	// output stage: apply mode, sign, saturation, and zero unless rendering
	logic [31:0] q_w, val_w;
	assign q_w = div_low_s[DIV_STEPS];

	always_comb begin
		unique case (mode_t'(mode_q))
			MODE_FROMTO: val_w = dneg_q ? first_q - q_w : first_q + q_w;
			MODE_PVA: begin
				if (div_neg_s[DIV_STEPS])
					val_w = (div_sat_s[DIV_STEPS] || q_w > 32'h8000_0000) ?
						32'h8000_0000 : -q_w;
				else
					val_w = (div_sat_s[DIV_STEPS] || q_w > 32'h7FFF_FFFF) ?
						32'h7FFF_FFFF : q_w;
			end
			default: val_w = first_q;
		endcase
		if (div_st_s[DIV_STEPS] != ST_RENDER)
			val_w = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv)
			m_tvalid <= div_vld_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= val_w;
			m_tuser <= div_st_s[DIV_STEPS];
		end
	end

	// a non-render result always carries a zero value
	a_zero_unless_render: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_RENDER |-> m_tdata == '0)
		else $error("non-render result with nonzero value");

	// the slave side only waits behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// a rendered FROMTO quotient leaves a remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[DIV_STEPS] && div_st_s[DIV_STEPS] == ST_RENDER &&
		mode_t'(mode_q) == MODE_FROMTO |-> div_rem_s[DIV_STEPS] < divisor_w)
		else $error("divider remainder out of range");

	// a held result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule
`default_nettype wire
